### rtl/core/ctb_pkg.sv
// ctb_pkg: shared types and constants for the cartesian tree builder
// used by ctb_cell and cartesian_tree_builder; no dependencies
package ctb_pkg;

  localparam int MAX_NODES_DEF = 1023;
  localparam int IDX_OUT_W     = 10;
  localparam int VALUE_W       = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] node_value;
    logic                      last_node;
  } item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] node_index;
    logic [IDX_OUT_W-1:0] parent_index;
    logic [IDX_OUT_W-1:0] left_child_index;
    logic [IDX_OUT_W-1:0] root_index;
    logic                 overflow;
  } result_t;

  // shift control shared by every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

endpackage

### rtl/core/ctb_cell.sv
// ctb_cell: one entry of the right-chain stack, shifts with its neighbours
// depends on ctb_pkg
module ctb_cell #(
  parameter int IDX_W = 10
) (
  input  logic                               clk,
  input  ctb_pkg::cell_ctrl_t                ctrl,
  input  logic [IDX_W-1:0]                   above_idx,
  input  logic signed [ctb_pkg::VALUE_W-1:0] above_value,
  input  logic [IDX_W-1:0]                   below_idx,
  input  logic signed [ctb_pkg::VALUE_W-1:0] below_value,
  output logic [IDX_W-1:0]                   idx,
  output logic signed [ctb_pkg::VALUE_W-1:0] value
);

  // push moves entries away from the top, pop moves them towards it
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      idx   <= above_idx;
      value <= above_value;
    end else if (ctrl.pop) begin
      idx   <= below_idx;
      value <= below_value;
    end
  end

endmodule

### rtl/core/cartesian_tree_builder.sv
// Builds a max-heap Cartesian tree from values arriving in key order. The right chain of the
// tree is held in a row of MAX_NODES shifting cells with the top of the chain in cell 0; each
// item is compared against cell 0 and entries with a strictly smaller value are popped, one
// per cycle. An item is accepted, then pops its entries, then is pushed and its result
// registered; no new item is taken before that. The result is held in an output register,
// so a stalled result only delays the push of the next item. Items past MAX_NODES in one set
// are reported with overflow set and leave the tree unchanged; last_node ends the set and
// clears the chain after its result.
// depends on ctb_pkg and ctb_cell
module cartesian_tree_builder #(
  parameter int MAX_NODES = ctb_pkg::MAX_NODES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ctb_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output ctb_pkg::result_t result
);

  localparam int IDX_W = $clog2(MAX_NODES + 1);

  ctb_pkg::state_t state;
  ctb_pkg::cell_ctrl_t ctrl;

  logic [IDX_W-1:0]                   depth;
  logic [IDX_W-1:0]                   count;
  logic [IDX_W-1:0]                   root;
  logic [IDX_W-1:0]                   cur_idx;
  logic [IDX_W-1:0]                   left;
  logic signed [ctb_pkg::VALUE_W-1:0] cur_value;
  logic                               cur_last;
  logic                               cur_ovf;

  logic [IDX_W-1:0]                   cell_idx   [MAX_NODES];
  logic signed [ctb_pkg::VALUE_W-1:0] cell_value [MAX_NODES];

  logic item_xfer, out_free, top_less, finish;
  ctb_pkg::result_t result_next;

  assign item_stall = (state != ctb_pkg::S_IDLE);
  assign item_xfer  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign top_less   = (depth != '0) && (cell_value[0] < cur_value);
  assign finish     = (state == ctb_pkg::S_POP) && out_free && (cur_ovf || !top_less);

  always_comb begin
    ctrl.pop  = (state == ctb_pkg::S_POP) && !cur_ovf && top_less;
    ctrl.push = finish && !cur_ovf;
  end

  // chain of cells, cell 0 is the top of the stack
  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    logic [IDX_W-1:0]                   a_idx, b_idx;
    logic signed [ctb_pkg::VALUE_W-1:0] a_val, b_val;
    if (i == 0) begin : g_top
      assign a_idx = cur_idx;
      assign a_val = cur_value;
    end else begin : g_mid
      assign a_idx = cell_idx[i-1];
      assign a_val = cell_value[i-1];
    end
    if (i == MAX_NODES - 1) begin : g_end
      assign b_idx = cell_idx[i];
      assign b_val = cell_value[i];
    end else begin : g_inner
      assign b_idx = cell_idx[i+1];
      assign b_val = cell_value[i+1];
    end
    ctb_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .above_idx   (a_idx),
      .above_value (a_val),
      .below_idx   (b_idx),
      .below_value (b_val),
      .idx         (cell_idx[i]),
      .value       (cell_value[i])
    );
  end

  always_comb begin
    if (cur_ovf) begin
      result_next.node_index       = '0;
      result_next.parent_index     = '0;
      result_next.left_child_index = '0;
      result_next.root_index       = (depth != '0) ? ctb_pkg::IDX_OUT_W'(root) : '0;
      result_next.overflow         = 1'b1;
    end else begin
      result_next.node_index       = ctb_pkg::IDX_OUT_W'(cur_idx);
      result_next.parent_index     = (depth != '0) ? ctb_pkg::IDX_OUT_W'(cell_idx[0]) : '0;
      result_next.left_child_index = ctb_pkg::IDX_OUT_W'(left);
      result_next.root_index       = (depth != '0) ? ctb_pkg::IDX_OUT_W'(root)
                                                   : ctb_pkg::IDX_OUT_W'(cur_idx);
      result_next.overflow         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ctb_pkg::S_IDLE;
      depth        <= '0;
      count        <= '0;
      root         <= '0;
      result_valid <= 1'b0;
    end else begin
      // a new result may land in the same cycle as the old one transfers
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ctb_pkg::S_IDLE: begin
          if (item_xfer) begin
            state     <= ctb_pkg::S_POP;
            cur_value <= item.node_value;
            cur_last  <= item.last_node;
            cur_ovf   <= (count >= IDX_W'(MAX_NODES));
            cur_idx   <= count + 1'b1;
            left      <= '0;
          end
        end
        ctb_pkg::S_POP: begin
          if (ctrl.pop) begin
            left  <= cell_idx[0];
            depth <= depth - 1'b1;
          end else if (finish) begin
            state  <= ctb_pkg::S_IDLE;
            result <= result_next;
            if (!cur_ovf && depth == '0) begin
              root <= cur_idx;
            end
            if (cur_last) begin
              depth <= '0;
              count <= '0;
            end else if (!cur_ovf) begin
              depth <= depth + 1'b1;
              count <= cur_idx;
            end
          end
        end
        default: state <= ctb_pkg::S_IDLE;
      endcase
    end
  end

  // the chain never holds more entries than nodes numbered in the set
  a_depth_le_count: assert property (@(posedge clk) disable iff (rst) depth <= count)
    else $error("chain depth exceeds node count");

  // each pop step removes exactly one entry
  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> depth == $past(depth) - 1'b1)
    else $error("pop did not shrink the chain by one");

  // an ignored item never carries a node number
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overflow |-> result.node_index == '0 && result.parent_index == '0)
    else $error("overflow result carries an index");

endmodule
